// ----- rtl/sipf_pkg.sv -----
// ============================================================================
// Servo instruction packet framer package
// Shared constants, command codes and the packet descriptor that travels
// from the command front end through the queue to the byte sequencer.
// ============================================================================
package sipf_pkg;

    localparam int MAX_DATA_BYTES = 2;
    localparam int ND_W           = $clog2(MAX_DATA_BYTES + 1);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HDR_BYTE       = 8'hff;
    localparam logic [7:0] LEN_PING       = 8'h2;
    localparam logic [7:0] LEN_READ       = 8'h4;
    localparam logic [7:0] LEN_WRITE_BASE = 8'd3;

    localparam logic [7:0] INSTR_PING      = 8'd1;
    localparam logic [7:0] INSTR_READ      = 8'd2;
    localparam logic [7:0] INSTR_WRITE     = 8'd3;
    localparam logic [7:0] INSTR_REG_WRITE = 8'd4;

    typedef enum logic [1:0] {
        OP_PING      = 2'd0,
        OP_READ      = 2'd1,
        OP_WRITE     = 2'd2,
        OP_REG_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_PING,
        KIND_READ,
        KIND_WRITE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        id;
        logic [7:0]        len;
        logic [7:0]        instr;
        logic [7:0]        addr;
        logic [7:0]        cnt;
        logic [7:0]        d0;
        logic [7:0]        d1;
        logic [ND_W-1:0]   nd;
    } desc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR0,
        ST_HDR1,
        ST_ID,
        ST_LEN,
        ST_INSTR,
        ST_ADDR,
        ST_CNT,
        ST_DATA,
        ST_SUM
    } step_t;

endpackage

// ----- rtl/servo_instruction_packet_framer.sv -----
// ============================================================================
// Servo instruction packet framer
// Turns one command transaction into a serial instruction packet: two header
// bytes, id, length, instruction, parameters and inverted checksum.
// ============================================================================
// Throughput: one byte per cycle while out_stall is low; a packet is 6 bytes (ping),
// 8 (read) or 7 + clamped data bytes (write).
// Packets follow one another with no gap while the descriptor queue holds the next.
// Reset clears the front-end valid, queue pointers, sequencer state and output valid.
module servo_instruction_packet_framer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] servo_id,
    input  logic [7:0] reg_address,
    input  logic [7:0] byte_count,
    input  logic [7:0] data_byte0,
    input  logic [7:0] data_byte1,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_byte,
    output logic       last_byte
);
    import sipf_pkg::*;

    logic  push_valid;
    logic  push_ready;
    desc_t push_desc;
    logic  pop_valid;
    logic  pop_ready;
    desc_t pop_desc;

    sipf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .servo_id    (servo_id),
        .reg_address (reg_address),
        .byte_count  (byte_count),
        .data_byte0  (data_byte0),
        .data_byte1  (data_byte1),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_desc   (push_desc)
    );

    sipf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    sipf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_byte   (tx_byte),
        .last_byte (last_byte)
    );

endmodule

// ----- rtl/sipf_front.sv -----
// ============================================================================
// Command front end
// Accepts a command transaction, classifies it into a packet descriptor and
// hands the descriptor to the queue.
// ============================================================================
module sipf_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     operation,
    input  logic [7:0]     servo_id,
    input  logic [7:0]     reg_address,
    input  logic [7:0]     byte_count,
    input  logic [7:0]     data_byte0,
    input  logic [7:0]     data_byte1,
    output logic           push_valid,
    input  logic           push_ready,
    output sipf_pkg::desc_t push_desc
);
    import sipf_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    desc_t           desc_reg;
    desc_t           desc_next;
    logic            accept;
    logic [ND_W-1:0] nd;

    assign in_stall   = valid_reg && !push_ready;
    assign accept     = in_valid && !in_stall;
    assign push_valid = valid_reg;
    assign push_desc  = desc_reg;

    // clamp write length to the data bytes carried
    assign nd = (byte_count > 8'(MAX_DATA_BYTES)) ? ND_W'(MAX_DATA_BYTES)
                                                   : byte_count[ND_W-1:0];

    always_comb
    begin
        desc_next      = desc_reg;
        valid_next     = valid_reg && !push_ready;
        if (accept)
        begin
            valid_next     = 1'b1;
            desc_next.id   = servo_id;
            desc_next.addr = reg_address;
            desc_next.cnt  = byte_count;
            desc_next.d0   = data_byte0;
            desc_next.d1   = data_byte1;
            desc_next.nd   = nd;
            unique case (op_t'(operation)) inside
                OP_PING:
                begin
                    desc_next.kind  = KIND_PING;
                    desc_next.len   = LEN_PING;
                    desc_next.instr = INSTR_PING;
                end
                OP_READ:
                begin
                    desc_next.kind  = KIND_READ;
                    desc_next.len   = LEN_READ;
                    desc_next.instr = INSTR_READ;
                end
                OP_WRITE, OP_REG_WRITE:
                begin
                    desc_next.kind  = KIND_WRITE;
                    desc_next.len   = LEN_WRITE_BASE + 8'(nd);
                    desc_next.instr = (op_t'(operation) == OP_REG_WRITE) ? INSTR_REG_WRITE
                                                                         : INSTR_WRITE;
                end
                default:
                begin
                    desc_next.kind  = KIND_PING;
                    desc_next.len   = LEN_PING;
                    desc_next.instr = INSTR_PING;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

// ----- rtl/sipf_queue.sv -----
// ============================================================================
// Descriptor queue
// Short FIFO of packet descriptors between the front end and the sequencer.
// ============================================================================
module sipf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  sipf_pkg::desc_t push_desc,
    output logic            pop_valid,
    input  logic            pop_ready,
    output sipf_pkg::desc_t pop_desc
);
    import sipf_pkg::*;

    desc_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- rtl/sipf_back.sv -----
// ============================================================================
// Packet byte sequencer
// Walks one descriptor through the packet fields, one byte per transaction,
// keeps the running checksum and drives the registered output.
// ============================================================================
module sipf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  sipf_pkg::desc_t pop_desc,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      tx_byte,
    output logic            last_byte
);
    import sipf_pkg::*;

    step_t           state_reg;
    step_t           state_next;
    desc_t           desc_reg;
    logic [7:0]      sum_reg;
    logic [7:0]      sum_next;
    logic [ND_W-1:0] data_cnt_reg;
    logic [ND_W-1:0] data_cnt_next;
    logic            out_valid_reg;
    logic [7:0]      tx_byte_reg;
    logic            last_byte_reg;
    logic            out_ready;
    logic            advance;
    logic            load;
    logic [7:0]      cur_byte;
    logic            cur_summed;
    logic            cur_last;

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = (state_reg != ST_IDLE) && out_ready;
    assign load      = pop_valid && ((state_reg == ST_IDLE) || ((state_reg == ST_SUM) && advance));
    assign pop_ready = load;

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last_byte = last_byte_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_HDR0;
                end
            end
            ST_HDR0:
            begin
                if (advance) state_next = ST_HDR1;
            end
            ST_HDR1:
            begin
                if (advance) state_next = ST_ID;
            end
            ST_ID:
            begin
                if (advance) state_next = ST_LEN;
            end
            ST_LEN:
            begin
                if (advance) state_next = ST_INSTR;
            end
            ST_INSTR:
            begin
                if (advance)
                begin
                    state_next = (desc_reg.kind == KIND_PING) ? ST_SUM : ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (advance)
                begin
                    if (desc_reg.kind == KIND_READ)
                    begin
                        state_next = ST_CNT;
                    end
                    else
                    begin
                        state_next = (desc_reg.nd == '0) ? ST_SUM : ST_DATA;
                    end
                end
            end
            ST_CNT:
            begin
                if (advance) state_next = ST_SUM;
            end
            ST_DATA:
            begin
                if (advance && (data_cnt_reg + 1'b1 == desc_reg.nd))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (advance)
                begin
                    state_next = pop_valid ? ST_HDR0 : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_byte   = HDR_BYTE;
        cur_summed = 1'b0;
        cur_last   = 1'b0;
        unique case (state_reg) inside
            ST_IDLE, ST_HDR0, ST_HDR1:
            begin
                cur_byte = HDR_BYTE;
            end
            ST_ID:
            begin
                cur_byte   = desc_reg.id;
                cur_summed = 1'b1;
            end
            ST_LEN:
            begin
                cur_byte   = desc_reg.len;
                cur_summed = 1'b1;
            end
            ST_INSTR:
            begin
                cur_byte   = desc_reg.instr;
                cur_summed = 1'b1;
            end
            ST_ADDR:
            begin
                cur_byte   = desc_reg.addr;
                cur_summed = 1'b1;
            end
            ST_CNT:
            begin
                cur_byte   = desc_reg.cnt;
                cur_summed = 1'b1;
            end
            ST_DATA:
            begin
                // an index past the two carried bytes would select zero; the clamp keeps nd at two or less
                if (data_cnt_reg == ND_W'(0))
                begin
                    cur_byte = desc_reg.d0;
                end
                else if (data_cnt_reg == ND_W'(1))
                begin
                    cur_byte = desc_reg.d1;
                end
                else
                begin
                    cur_byte = 8'h00;
                end
                cur_summed = 1'b1;
            end
            ST_SUM:
            begin
                cur_byte = ~sum_reg;
                cur_last = 1'b1;
            end
            default:
            begin
                cur_byte = HDR_BYTE;
            end
        endcase
    end

    always_comb
    begin
        sum_next      = sum_reg;
        data_cnt_next = data_cnt_reg;
        if (load)
        begin
            sum_next      = '0;
            data_cnt_next = '0;
        end
        else if (advance)
        begin
            if (cur_summed)
            begin
                sum_next = sum_reg + cur_byte;
            end
            if (state_reg == ST_DATA)
            begin
                data_cnt_next = data_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            data_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            data_cnt_reg <= data_cnt_next;
            if (out_ready)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= pop_desc;
        end
        if (advance)
        begin
            tx_byte_reg   <= cur_byte;
            last_byte_reg <= cur_last;
        end
    end

    a_sum_ends_packet: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) && advance |=> out_valid_reg && last_byte_reg
    ) else $error("checksum byte not flagged as last");

    a_data_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (data_cnt_reg < desc_reg.nd)
    ) else $error("data byte count past clamped length");

    a_load_between_packets: assert property (
        @(posedge clk) disable iff (!rst_n)
        load |-> (state_reg == ST_IDLE) || (state_reg == ST_SUM)
    ) else $error("descriptor loaded mid packet");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Servo instruction packet framer testbench
// Sends ping, read, write and deferred write commands and predicts each
// instruction packet byte by byte: header, id, length, instruction,
// parameters and inverted checksum. Every byte the block emits is compared
// with the oldest predicted byte. Both sides idle at random outside a calm stretch.
// ============================================================================
import sipf_pkg::*;

typedef struct {
    logic [7:0] tx;
    logic       last;
} packet_byte_t;

class packet_scoreboard;

    packet_byte_t line_bytes[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    function void add_byte(logic [7:0] b, logic last);
        packet_byte_t pb;
        pb.tx   = b;
        pb.last = last;
        line_bytes = {line_bytes, pb};
    endfunction

    function void note_command(op_t op, logic [7:0] id, logic [7:0] addr,
                               logic [7:0] cnt, logic [7:0] d0, logic [7:0] d1);
        logic [7:0] body[$];
        logic [7:0] sum;
        int         nd;
        body = {body, id};
        case (op)
            OP_PING:
            begin
                body = {body, LEN_PING};
                body = {body, INSTR_PING};
            end
            OP_READ:
            begin
                body = {body, LEN_READ};
                body = {body, INSTR_READ};
                body = {body, addr};
                body = {body, cnt};
            end
            default:
            begin
                nd = (int'(cnt) > MAX_DATA_BYTES) ? MAX_DATA_BYTES : int'(cnt);
                body = {body, LEN_WRITE_BASE + 8'(nd)};
                body = {body, ((op == OP_REG_WRITE) ? INSTR_REG_WRITE : INSTR_WRITE)};
                body = {body, addr};
                for (int i = 0; i < nd; i++)
                    body = {body, ((i == 0) ? d0 : ((i == 1) ? d1 : 8'h00))};
            end
        endcase
        add_byte(HDR_BYTE, 1'b0);
        add_byte(HDR_BYTE, 1'b0);
        sum = 8'h00;
        foreach (body[i])
        begin
            sum = sum + body[i];
            add_byte(body[i], 1'b0);
        end
        add_byte(~sum, 1'b1);
    endfunction

    function void check_byte(logic [7:0] tx, logic last);
        packet_byte_t pb;
        if (line_bytes.size() == 0)
        begin
            $error("tx_byte: expected none, actual %02h", tx);
            errors++;
            return;
        end
        pb = line_bytes.pop_front();
        if (tx !== pb.tx)
        begin
            $error("tx_byte: expected %02h, actual %02h", pb.tx, tx);
            errors++;
        end
        if (last !== pb.last)
        begin
            $error("last_byte: expected %0b, actual %0b", pb.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return line_bytes.size();
    endfunction

endclass

module tb_top;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [1:0] operation   = 2'd0;
    logic [7:0] servo_id    = 8'd0;
    logic [7:0] reg_address = 8'd0;
    logic [7:0] byte_count  = 8'd0;
    logic [7:0] data_byte0  = 8'd0;
    logic [7:0] data_byte1  = 8'd0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] tx_byte;
    logic       last_byte;

    logic             calm = 1'b0;
    packet_scoreboard sb   = new();

    servo_instruction_packet_framer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .servo_id    (servo_id),
        .reg_address (reg_address),
        .byte_count  (byte_count),
        .data_byte0  (data_byte0),
        .data_byte1  (data_byte1),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .last_byte   (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 31);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_byte(tx_byte, last_byte);

    task automatic idle_gap();
        if (!calm)
            while ($urandom_range(99) < 31)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
    endtask

    task automatic send_command(op_t op, logic [7:0] id, logic [7:0] addr,
                                logic [7:0] cnt, logic [7:0] d0, logic [7:0] d1);
        idle_gap();
        in_valid    <= 1'b1;
        operation   <= op;
        servo_id    <= id;
        reg_address <= addr;
        byte_count  <= cnt;
        data_byte0  <= d0;
        data_byte1  <= d1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(op, id, addr, cnt, d0, d1);
    endtask

    task automatic send_random_command();
        op_t        op;
        logic [7:0] cnt;
        op = op_t'($urandom_range(3));
        if ($urandom_range(9) < 7)
            cnt = 8'($urandom_range(3));
        else
            cnt = 8'($urandom_range(255));
        send_command(op, 8'($urandom_range(255)), 8'($urandom_range(255)), cnt,
                     8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic drain_packets();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        send_command(OP_PING,      8'd0,   8'h5a, 8'd7,   8'hff, 8'hff);
        send_command(OP_PING,      8'd254, 8'h00, 8'd0,   8'h00, 8'h00);
        send_command(OP_PING,      8'd255, 8'hff, 8'd255, 8'h12, 8'h34);
        send_command(OP_READ,      8'd1,   8'h00, 8'd0,   8'h00, 8'h00);
        send_command(OP_READ,      8'd255, 8'hff, 8'd255, 8'hff, 8'hff);
        send_command(OP_READ,      8'd254, 8'h24, 8'd1,   8'h00, 8'h00);
        send_command(OP_WRITE,     8'd3,   8'h1e, 8'd0,   8'haa, 8'h55);
        send_command(OP_WRITE,     8'd4,   8'h1e, 8'd1,   8'hff, 8'h00);
        send_command(OP_WRITE,     8'd5,   8'h1e, 8'd2,   8'h00, 8'hff);
        send_command(OP_WRITE,     8'd6,   8'hff, 8'd3,   8'hff, 8'hff);
        send_command(OP_WRITE,     8'd254, 8'h00, 8'd255, 8'h00, 8'h00);
        send_command(OP_REG_WRITE, 8'd0,   8'h20, 8'd0,   8'h11, 8'h22);
        send_command(OP_REG_WRITE, 8'd7,   8'h20, 8'd1,   8'h80, 8'h01);
        send_command(OP_REG_WRITE, 8'd255, 8'hff, 8'd2,   8'hff, 8'hff);
        send_command(OP_REG_WRITE, 8'd254, 8'h00, 8'd255, 8'h00, 8'h00);
        send_command(OP_WRITE,     8'd255, 8'hff, 8'd2,   8'hff, 8'hff);
        send_command(OP_READ,      8'd0,   8'h80, 8'd128, 8'h00, 8'h00);
        drain_packets();

        for (int n = 0; n < 450; n++)
        begin
            calm = (n >= 150 && n < 230);
            if (n == 300)
                drain_packets();
            send_random_command();
        end
        calm = 1'b0;

        drain_packets();
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sipf_pkg.sv
rtl/sipf_front.sv
rtl/sipf_queue.sv
rtl/sipf_back.sv
rtl/servo_instruction_packet_framer.sv
sim/tb_top.sv
